// ===== rtl/hsvrgb_pkg.sv =====
package hsvrgb_pkg;

    // field widths of the stream items
    localparam int HUE_W  = 9;
    localparam int FRAC_W = 13;
    localparam int CHAN_W = 8;

    // default fraction bits of the saturation and brightness inputs
    localparam int FRAC_BITS_DEF = 12;

    // sum of one color pattern term and m, one bit of headroom
    localparam int SUM_W = FRAC_W + 1;

    localparam logic [CHAN_W-1:0] CHAN_MAX = '1;
    localparam logic [7:0]        CHAN_SCALE = 8'd255;

    // hue above this gives black
    localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(360);

    // hue position in hundredths of a sector: floor(hue * 5 / 3)
    localparam int POS_W      = 10;
    localparam int HUE5_W     = HUE_W + 3;
    localparam int DIV3_MUL   = 2731;     // ceil(2^13 / 3)
    localparam int DIV3_SHIFT = 13;
    localparam int DIV3_W     = HUE5_W + 12;

    // position within a sector pair and the x weight
    localparam int REM_W  = 8;
    localparam int COEF_W = 7;
    localparam logic [COEF_W-1:0] SECTOR_SPAN = COEF_W'(100);

    // x = chroma * coef / 100 through a reciprocal multiply
    localparam int T_W          = FRAC_W + COEF_W;
    localparam int DIV100_MUL   = 1342178;  // ceil(2^27 / 100)
    localparam int DIV100_SHIFT = 27;
    localparam int DIV100_W     = 21;
    localparam int Q_W          = T_W + DIV100_W;

    // 60-degree sector; hue 360 lands in the last one
    typedef enum logic [2:0] {
        SEC_R_GUP  = 3'd0,
        SEC_G_RDN  = 3'd1,
        SEC_G_BUP  = 3'd2,
        SEC_B_GDN  = 3'd3,
        SEC_B_RUP  = 3'd4,
        SEC_R_BDN  = 3'd5
    } sector_t;

endpackage

// ===== rtl/hsvrgb_chan.sv =====
module hsvrgb_chan
    import hsvrgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              load,
    input  logic [SUM_W-1:0]  frac_in,
    output logic [CHAN_W-1:0] chan_out
);

    localparam int PROD_W = SUM_W + 8;

    logic [PROD_W-1:0] scaled;
    logic [PROD_W-1:0] level;
    logic [CHAN_W-1:0] chan_next;
    logic [CHAN_W-1:0] chan_reg;

    // scale by 255, truncate, clip to full scale
    assign scaled    = PROD_W'(frac_in) * PROD_W'(CHAN_SCALE);
    assign level     = scaled >> FRAC_BITS;
    assign chan_next = (level > PROD_W'(CHAN_MAX)) ? CHAN_MAX : level[CHAN_W-1:0];

    always_ff @(posedge aclk) begin
        if (load) begin
            chan_reg <= chan_next;
        end
    end

    assign chan_out = chan_reg;

endmodule

// ===== rtl/hsv_to_rgb_converter_core.sv =====
// Throughput: one item per cycle; five register stages, each with its own
// valid bit, so bubbles close up and a stall on m_tready holds every item.
// Reset: synchronous, aresetn low clears all stage valid bits; data
// registers are not reset.
module hsv_to_rgb_converter_core
    import hsvrgb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // hue[8:0], saturation[21:9], brightness[34:22], zero[39:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam longint ONE_Q = longint'(1) << FRAC_BITS;
    localparam logic [FRAC_W-1:0] ONE_CLAMP = FRAC_W'(ONE_Q);

    // ---------------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its successor loads
    // ---------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5     = !v5_reg || m_tready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_tvalid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: clamp fractions, chroma product, hue position by reciprocal
    // ---------------------------------------------------------------------
    logic [HUE_W-1:0]    hue_in;
    logic [FRAC_W-1:0]   sat_in, val_in, sat_c, val_c;
    logic [2*FRAC_W-1:0] vs_prod;
    logic [HUE5_W-1:0]   hue_x5;
    logic [DIV3_W-1:0]   pos_prod;
    logic [FRAC_W-1:0]   chroma1_next;
    logic [POS_W-1:0]    pos1_next;
    logic                black1_next;

    assign hue_in = s_tdata[8:0];
    assign sat_in = s_tdata[21:9];
    assign val_in = s_tdata[34:22];

    // clamp anything above 1.0 down to 1.0
    assign sat_c = (64'(sat_in) > 64'(ONE_Q)) ? ONE_CLAMP : sat_in;
    assign val_c = (64'(val_in) > 64'(ONE_Q)) ? ONE_CLAMP : val_in;

    assign vs_prod      = (2*FRAC_W)'(val_c) * (2*FRAC_W)'(sat_c);
    assign chroma1_next = FRAC_W'(vs_prod >> FRAC_BITS);

    // floor(5*hue/3) as a multiply by ceil(2^13/3); exact for 5*hue < 2^13
    assign hue_x5      = HUE5_W'(hue_in) * HUE5_W'(5);
    assign pos_prod    = DIV3_W'(hue_x5) * DIV3_W'(DIV3_MUL);
    assign pos1_next   = POS_W'(pos_prod >> DIV3_SHIFT);
    assign black1_next = hue_in > HUE_MAX;

    logic [FRAC_W-1:0] chroma1_reg, val1_reg;
    logic [POS_W-1:0]  pos1_reg;
    logic              black1_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            chroma1_reg <= chroma1_next;
            val1_reg    <= val_c;
            pos1_reg    <= pos1_next;
            black1_reg  <= black1_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: sector, distance from sector-pair middle, chroma * weight
    // ---------------------------------------------------------------------
    sector_t           sec2_next;
    logic [REM_W-1:0]  rem2;
    logic [COEF_W-1:0] dist2, coef2;
    logic [T_W-1:0]    t2_next;
    logic [FRAC_W-1:0] m2_next;

    always_comb begin
        if (pos1_reg >= POS_W'(500))      sec2_next = SEC_R_BDN;
        else if (pos1_reg >= POS_W'(400)) sec2_next = SEC_B_RUP;
        else if (pos1_reg >= POS_W'(300)) sec2_next = SEC_B_GDN;
        else if (pos1_reg >= POS_W'(200)) sec2_next = SEC_G_BUP;
        else if (pos1_reg >= POS_W'(100)) sec2_next = SEC_G_RDN;
        else                              sec2_next = SEC_R_GUP;
    end

    // pos mod 200; pos never exceeds 600 for a hue that is not black
    always_comb begin
        if (pos1_reg >= POS_W'(600))      rem2 = '0;
        else if (pos1_reg >= POS_W'(400)) rem2 = REM_W'(pos1_reg - POS_W'(400));
        else if (pos1_reg >= POS_W'(200)) rem2 = REM_W'(pos1_reg - POS_W'(200));
        else                              rem2 = REM_W'(pos1_reg);
    end

    assign dist2   = (rem2 >= REM_W'(SECTOR_SPAN)) ? COEF_W'(rem2 - REM_W'(SECTOR_SPAN))
                                                   : COEF_W'(REM_W'(SECTOR_SPAN) - rem2);
    assign coef2   = SECTOR_SPAN - dist2;
    assign t2_next = T_W'(chroma1_reg) * T_W'(coef2);
    assign m2_next = val1_reg - chroma1_reg;

    logic [T_W-1:0]    t2_reg;
    logic [FRAC_W-1:0] chroma2_reg, m2_reg;
    sector_t           sec2_reg;
    logic              black2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            t2_reg      <= t2_next;
            chroma2_reg <= chroma1_reg;
            m2_reg      <= m2_next;
            sec2_reg    <= sec2_next;
            black2_reg  <= black1_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: x = floor(t / 100) by reciprocal multiply
    // ---------------------------------------------------------------------
    logic [Q_W-1:0]    q3;
    logic [FRAC_W-1:0] x3_next;

    assign q3      = Q_W'(t2_reg) * Q_W'(DIV100_MUL);
    assign x3_next = FRAC_W'(q3 >> DIV100_SHIFT);

    logic [FRAC_W-1:0] x3_reg, chroma3_reg, m3_reg;
    sector_t           sec3_reg;
    logic              black3_reg;

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            x3_reg      <= x3_next;
            chroma3_reg <= chroma2_reg;
            m3_reg      <= m2_reg;
            sec3_reg    <= sec2_reg;
            black3_reg  <= black2_reg;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: pick the sector pattern and add m; black forces zero
    // ---------------------------------------------------------------------
    logic [FRAC_W-1:0] pr, pg, pb;
    logic [SUM_W-1:0]  r4_next, g4_next, b4_next;

    always_comb begin
        case (sec3_reg)
            SEC_R_GUP: begin pr = chroma3_reg; pg = x3_reg;      pb = '0;          end
            SEC_G_RDN: begin pr = x3_reg;      pg = chroma3_reg; pb = '0;          end
            SEC_G_BUP: begin pr = '0;          pg = chroma3_reg; pb = x3_reg;      end
            SEC_B_GDN: begin pr = '0;          pg = x3_reg;      pb = chroma3_reg; end
            SEC_B_RUP: begin pr = x3_reg;      pg = '0;          pb = chroma3_reg; end
            default:   begin pr = chroma3_reg; pg = '0;          pb = x3_reg;      end
        endcase
    end

    assign r4_next = black3_reg ? '0 : SUM_W'(pr) + SUM_W'(m3_reg);
    assign g4_next = black3_reg ? '0 : SUM_W'(pg) + SUM_W'(m3_reg);
    assign b4_next = black3_reg ? '0 : SUM_W'(pb) + SUM_W'(m3_reg);

    logic [SUM_W-1:0] r4_reg, g4_reg, b4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            r4_reg <= r4_next;
            g4_reg <= g4_next;
            b4_reg <= b4_next;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: scale to 8 bits and saturate; these are the output registers
    // ---------------------------------------------------------------------
    logic [CHAN_W-1:0] red, green, blue;

    hsvrgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_r (
        .aclk     (aclk),
        .load     (rdy5),
        .frac_in  (r4_reg),
        .chan_out (red)
    );

    hsvrgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_g (
        .aclk     (aclk),
        .load     (rdy5),
        .frac_in  (g4_reg),
        .chan_out (green)
    );

    hsvrgb_chan #(.FRAC_BITS(FRAC_BITS)) u_chan_b (
        .aclk     (aclk),
        .load     (rdy5),
        .frac_in  (b4_reg),
        .chan_out (blue)
    );

    assign m_tvalid = v5_reg;
    assign m_tdata  = {blue, green, red};

endmodule
